[hw/rtl/afr_pkg.sv]
// Shared types, constants and helpers of the analog frame receiver.
package afr_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned FRAME_CHANNELS   = 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam logic [7:0] CHAR_STX  = 8'h02;
  localparam logic [7:0] CHAR_ETX  = 8'h03;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // Byte positions inside the frame.
  localparam logic [4:0] POS_STX       = 5'd0;
  localparam logic [4:0] POS_HDR0      = 5'd1;
  localparam logic [4:0] POS_HDR1      = 5'd2;
  localparam logic [4:0] POS_DIG_FIRST = 5'd3;
  localparam logic [4:0] POS_DIG_LAST  = 5'd26;
  localparam logic [4:0] POS_ETX       = 5'd27;
  localparam logic [4:0] SUM_LEN       = 5'd28;

  localparam logic [1:0] DIGITS_LAST = 2'd2;

  // APB register map.
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_START = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_CKSUM   = 3'd2,
    ST_FORMAT  = 3'd3,
    ST_BADHEX  = 3'd4
  } status_e;

  // Report handed from the parser to the emitter.
  typedef struct packed {
    logic    frame;   // 1: channel results, 0: one status result
    status_e status;
  } rpt_t;

  // Decode an uppercase hex digit: {valid, nibble}, nibble 0 when not valid.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[hw/rtl/afr_if.sv]
// Stream interfaces for request words and result words.
interface afr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface afr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel;
  logic [11:0] value;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output channel, output value, output status,
                  output last, input ready);
  modport sink   (input valid, input channel, input value, input status,
                  input last, output ready);
endinterface

[hw/rtl/afr_regs.sv]
// APB configuration register block holding the timeout limit.
module afr_regs
  import afr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [15:0]           timeout_ticks_o
);

  logic [15:0] timeout_q, timeout_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en && paddr[2] == REG_TIMEOUT) begin
      timeout_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata          = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;
  assign timeout_ticks_o = timeout_q;

endmodule

[hw/rtl/afr_parser.sv]
// Input register, frame tracking state and channel digit store.
module afr_parser
  import afr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  afr_in_if.sink      rx_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic        emit_free_i,
  output logic        rpt_push_o,
  output rpt_t        rpt_o,
  output logic [11:0] chan_val_o [NUM_CHANNELS],
  output logic        chan_ok_o  [NUM_CHANNELS]
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic        in_vld_q;
  logic [1:0]  in_req_q;
  logic [7:0]  in_byte_q;

  logic        armed_q, armed_d;
  logic [4:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic        fmt_ok_q, fmt_ok_d;
  logic [15:0] tick_q, tick_d, tick_inc;
  logic [1:0]  dig_q, dig_d;
  logic [2:0]  chan_q, chan_d;

  logic [11:0] chan_val_q [NUM_CHANNELS];
  logic        chan_ok_q  [NUM_CHANNELS];

  logic        rpt_hit;
  rpt_t        rpt_d;
  logic        wr_en;
  logic        wr_first;
  logic [4:0]  hex;
  logic        consume;

  assign hex      = hex_nibble(in_byte_q);
  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;

  always_comb begin
    armed_d    = armed_q;
    byte_cnt_d = byte_cnt_q;
    sum_d      = sum_q;
    fmt_ok_d   = fmt_ok_q;
    tick_d     = tick_q;
    dig_d      = dig_q;
    chan_d     = chan_q;
    rpt_hit    = 1'b0;
    rpt_d      = '{frame: 1'b0, status: ST_OK};
    wr_en      = 1'b0;
    wr_first   = (dig_q == 2'd0);
    if (in_vld_q) begin
      unique case (req_e'(in_req_q))
        REQ_START: begin
          armed_d    = 1'b1;
          byte_cnt_d = 5'd0;
          sum_d      = 8'd0;
          fmt_ok_d   = 1'b1;
          tick_d     = 16'd0;
          dig_d      = 2'd0;
          chan_d     = 3'd0;
        end
        REQ_TICK: begin
          if (armed_q) begin
            tick_d = tick_inc;
            if (tick_inc >= timeout_ticks_i) begin
              armed_d      = 1'b0;
              rpt_hit      = 1'b1;
              rpt_d.status = ST_TIMEOUT;
            end
          end
        end
        REQ_BYTE: begin
          if (armed_q) begin
            if (byte_cnt_q < SUM_LEN) begin
              sum_d      = sum_q + in_byte_q;
              byte_cnt_d = byte_cnt_q + 5'd1;
              if (byte_cnt_q == POS_STX) begin
                if (in_byte_q != CHAR_STX) fmt_ok_d = 1'b0;
              end else if (byte_cnt_q == POS_HDR0) begin
                if (in_byte_q != CHAR_ZERO) fmt_ok_d = 1'b0;
              end else if (byte_cnt_q == POS_HDR1) begin
                if (in_byte_q != CHAR_ONE) fmt_ok_d = 1'b0;
              end else if (byte_cnt_q == POS_ETX) begin
                if (in_byte_q != CHAR_ETX) fmt_ok_d = 1'b0;
              end else if (byte_cnt_q >= POS_DIG_FIRST && byte_cnt_q <= POS_DIG_LAST) begin
                // Only reported channels are stored; all digits still count.
                wr_en = ({1'b0, chan_q} < 4'(NUM_CHANNELS));
                if (dig_q == DIGITS_LAST) begin
                  dig_d  = 2'd0;
                  chan_d = chan_q + 3'd1;
                end else begin
                  dig_d = dig_q + 2'd1;
                end
              end
            end else begin
              // Checksum byte closes the frame.
              armed_d    = 1'b0;
              byte_cnt_d = 5'd0;
              rpt_hit    = 1'b1;
              if (in_byte_q != sum_q) begin
                rpt_d.status = ST_CKSUM;
              end else if (!fmt_ok_q) begin
                rpt_d.status = ST_FORMAT;
              end else begin
                rpt_d.frame = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold an item that reports until the emitter can take its results.
  assign consume    = in_vld_q && (!rpt_hit || emit_free_i);
  assign rx_i.ready = !in_vld_q || consume;
  assign rpt_push_o = consume && rpt_hit;
  assign rpt_o      = rpt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      armed_q    <= 1'b0;
      byte_cnt_q <= 5'd0;
      sum_q      <= 8'd0;
      fmt_ok_q   <= 1'b1;
      tick_q     <= 16'd0;
      dig_q      <= 2'd0;
      chan_q     <= 3'd0;
    end else begin
      if (rx_i.ready) begin
        in_vld_q <= rx_i.valid;
      end
      if (consume) begin
        armed_q    <= armed_d;
        byte_cnt_q <= byte_cnt_d;
        sum_q      <= sum_d;
        fmt_ok_q   <= fmt_ok_d;
        tick_q     <= tick_d;
        dig_q      <= dig_d;
        chan_q     <= chan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_req_q  <= rx_i.req_type;
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Digit store: the first digit of a channel restarts its value and flag.
  always_ff @(posedge clk_i) begin
    if (consume && wr_en) begin
      if (wr_first) begin
        chan_val_q[chan_q[IDX_W-1:0]] <= {8'd0, hex[3:0]};
        chan_ok_q[chan_q[IDX_W-1:0]]  <= hex[4];
      end else begin
        chan_val_q[chan_q[IDX_W-1:0]] <= {chan_val_q[chan_q[IDX_W-1:0]][7:0], hex[3:0]};
        chan_ok_q[chan_q[IDX_W-1:0]]  <= chan_ok_q[chan_q[IDX_W-1:0]] & hex[4];
      end
    end
  end

  assign chan_val_o = chan_val_q;
  assign chan_ok_o  = chan_ok_q;

endmodule

[hw/rtl/afr_emitter.sv]
// Result emitter: snapshot of a finished report, streamed out one word a cycle while res_o.ready is high.
module afr_emitter
  import afr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rpt_push_i,
  input  rpt_t        rpt_i,
  input  logic [11:0] chan_val_i [NUM_CHANNELS],
  input  logic        chan_ok_i  [NUM_CHANNELS],
  output logic        emit_free_o,
  afr_out_if.source   res_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  rpt_t             rpt_q;
  logic [11:0]      val_q [NUM_CHANNELS];
  logic             ok_q  [NUM_CHANNELS];

  logic             is_last;
  logic             taken;
  logic             cur_ok;

  assign is_last = !rpt_q.frame || (idx_q == IDX_LAST);
  assign taken   = busy_q && res_o.ready;
  assign cur_ok  = ok_q[idx_q];

  assign emit_free_o = !busy_q || (taken && is_last);

  assign res_o.valid   = busy_q;
  assign res_o.channel = rpt_q.frame ? 3'(idx_q) : 3'd0;
  assign res_o.value   = (rpt_q.frame && cur_ok) ? val_q[idx_q] : 12'd0;
  assign res_o.status  = rpt_q.frame ? (cur_ok ? ST_OK : ST_BADHEX) : rpt_q.status;
  assign res_o.last    = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (rpt_push_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (taken) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  // Snapshot the digit store so a new frame may fill it while results drain.
  always_ff @(posedge clk_i) begin
    if (rpt_push_i) begin
      rpt_q <= rpt_i;
      val_q <= chan_val_i;
      ok_q  <= chan_ok_i;
    end
  end

endmodule

[hw/rtl/analog_frame_receiver.sv]
// Top level of the analog frame receiver: 29-byte reply frame to channel results.
// A word is registered in the input register at acceptance and processed there; a report
//   loads the emitter, whose first result shows in the cycle after. One request word is
//   taken per cycle, but a reporting word (closing byte, timeout tick) waits in the input
//   register while an earlier report drains at one result word a cycle while res_o is ready.
// Reset (rst_ni, async, active low) disarms, sets the timeout to 100; digit store kept.
module analog_frame_receiver
  import afr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  afr_in_if.sink                rx_i,
  afr_out_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] timeout_ticks;
  logic        emit_free;
  logic        rpt_push;
  rpt_t        rpt;
  logic [11:0] chan_val [NUM_CHANNELS];
  logic        chan_ok  [NUM_CHANNELS];

  // Configuration: timeout limit. The user must write it only while idle; the block does not enforce this.
  afr_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .timeout_ticks_o (timeout_ticks)
  );

  // Track header, digits, running checksum and tick count; raise a report
  // on timeout or on the checksum byte.
  afr_parser #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_i            (rx_i),
    .timeout_ticks_i (timeout_ticks),
    .emit_free_i     (emit_free),
    .rpt_push_o      (rpt_push),
    .rpt_o           (rpt),
    .chan_val_o      (chan_val),
    .chan_ok_o       (chan_ok)
  );

  // Drain a report: one status word, or one word per channel.
  afr_emitter #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rpt_push_i  (rpt_push),
    .rpt_i       (rpt),
    .chan_val_i  (chan_val),
    .chan_ok_i   (chan_ok),
    .emit_free_o (emit_free),
    .res_o       (res_o)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the analog frame receiver: directed frames, random traffic, APB.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  // Sizes and codes the bench relies on.
  localparam int unsigned N_CH         = NUM_CHANNELS_DEF;
  localparam int          FRAME_BYTES  = 29;
  localparam int          DIGITS       = 3;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = APB_ADDR_W'(4 * REG_TIMEOUT);
  localparam int          DRAIN_CYCLES = 6;     // registered input plus emitter, with margin
  localparam int          HOLD_CYCLES  = 300;   // long output hold-off in the pressure test
  localparam int          LIMIT_NS     = 5_000_000;

  typedef logic [FRAME_BYTES-1:0][7:0]     frame_t;
  typedef logic [FRAME_CHANNELS-1:0][11:0] levels_t;

  // One result word as the block should present it.
  typedef struct packed {
    logic [2:0]  channel;
    logic [11:0] value;
    status_e     status;
    logic        last;
  } chan_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  afr_in_if  rx_if ();
  afr_out_if res_if ();

  analog_frame_receiver #(
    .NUM_CHANNELS(N_CH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit: far above the slowest idling phase and the long hold-off combined.
  initial begin
    #(LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of the receiver's state and timeout register.
  // ---------------------------------------------------------------------------
  bit          arm_q;
  logic [4:0]  pos_q;
  logic [7:0]  sum_q;
  bit          fmt_ok_q;
  logic [15:0] ticks_q;
  levels_t     level_q;
  logic [FRAME_CHANNELS-1:0] digit_good_q;
  logic [15:0] timeout_cfg;

  chan_word_t  pending_words[$];   // result words still owed by the block

  // Traffic shaping, changed per phase.
  int          send_idle_pct;
  int          rx_stall_pct;
  bit          rx_hold;

  // Bookkeeping.
  int          fail_count;
  int          words_taken;
  int          words_seen;
  int          status_seen[5];
  chan_word_t  head_w;

  // Decode an uppercase hex digit to {valid, nibble}.
  function automatic logic [4:0] digit_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void clear_frame_state();
    pos_q        = '0;
    sum_q        = '0;
    fmt_ok_q     = 1'b1;
    ticks_q      = '0;
    level_q      = '0;
    digit_good_q = '1;
  endfunction

  // Advance the predictor by one accepted request word and queue the result words
  // it causes. Returns 0 when the block simply ignores the word.
  function automatic bit predict_word(input logic [1:0] req, input logic [7:0] b);
    chan_word_t w;
    logic [4:0] d;
    int         ch;
    if (req == REQ_START) begin
      // Arm and clear, also when a frame is already under way.
      clear_frame_state();
      arm_q = 1'b1;
      return 1'b1;
    end
    if (!arm_q) return 1'b0;
    if (req == REQ_TICK) begin
      if (ticks_q != 16'hFFFF) ticks_q++;
      if (ticks_q >= timeout_cfg) begin
        arm_q = 1'b0;
        w = '{channel: '0, value: '0, status: ST_TIMEOUT, last: 1'b1};
        pending_words.push_back(w);
      end
      return 1'b1;
    end
    if (req != REQ_BYTE) return 1'b0;

    if (pos_q < SUM_LEN) begin
      // Frame body: accumulate the checksum and check header, digits and trailer.
      sum_q = sum_q + b;
      if (pos_q == POS_STX) begin
        if (b != CHAR_STX) fmt_ok_q = 1'b0;
      end else if (pos_q == POS_HDR0) begin
        if (b != CHAR_ZERO) fmt_ok_q = 1'b0;
      end else if (pos_q == POS_HDR1) begin
        if (b != CHAR_ONE) fmt_ok_q = 1'b0;
      end else if (pos_q == POS_ETX) begin
        if (b != CHAR_ETX) fmt_ok_q = 1'b0;
      end else begin
        ch = (int'(pos_q) - int'(POS_DIG_FIRST)) / DIGITS;
        d  = digit_of(b);
        if (!d[4]) digit_good_q[ch] = 1'b0;
        level_q[ch] = {level_q[ch][7:0], d[3:0]};
      end
      pos_q++;
      return 1'b1;
    end

    // Checksum byte closes the frame; a bad checksum wins over a bad format.
    arm_q = 1'b0;
    pos_q = '0;
    if (b != sum_q) begin
      w = '{channel: '0, value: '0, status: ST_CKSUM, last: 1'b1};
      pending_words.push_back(w);
    end else if (!fmt_ok_q) begin
      w = '{channel: '0, value: '0, status: ST_FORMAT, last: 1'b1};
      pending_words.push_back(w);
    end else begin
      for (int k = 0; k < int'(N_CH); k++) begin
        w.channel = 3'(k);
        w.value   = digit_good_q[k] ? level_q[k] : 12'd0;
        w.status  = digit_good_q[k] ? ST_OK : ST_BADHEX;
        w.last    = (k == int'(N_CH) - 1);
        pending_words.push_back(w);
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame building.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
  endfunction

  // Recompute the checksum byte over the first 28 bytes.
  function automatic frame_t seal(input frame_t f);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < int'(SUM_LEN); i++) s = s + f[i];
    f[SUM_LEN] = s;
    return f;
  endfunction

  function automatic frame_t build_frame(input levels_t lv);
    frame_t f;
    f           = '0;
    f[POS_STX]  = CHAR_STX;
    f[POS_HDR0] = CHAR_ZERO;
    f[POS_HDR1] = CHAR_ONE;
    for (int ch = 0; ch < FRAME_CHANNELS; ch++) begin
      for (int d = 0; d < DIGITS; d++) begin
        f[int'(POS_DIG_FIRST) + DIGITS * ch + d] = hex_char(lv[ch][11 - 4 * d -: 4]);
      end
    end
    f[POS_ETX] = CHAR_ETX;
    return seal(f);
  endfunction

  // Random levels, with the extremes showing up often.
  function automatic levels_t random_levels();
    levels_t lv;
    for (int ch = 0; ch < FRAME_CHANNELS; ch++) begin
      case ($urandom_range(5))
        0:       lv[ch] = 12'h000;
        1:       lv[ch] = 12'hFFF;
        default: lv[ch] = 12'($urandom_range(4095));
      endcase
    end
    return lv;
  endfunction

  // Replace one digit with a lowercase letter or any other non-hex byte.
  function automatic frame_t spoil_digit(input frame_t f);
    int         p;
    logic [7:0] c;
    logic [4:0] dc;
    p = int'(POS_DIG_FIRST) + $urandom_range(int'(POS_DIG_LAST - POS_DIG_FIRST));
    if ($urandom_range(1) == 0) begin
      c = 8'("a") + 8'($urandom_range(5));
    end else begin
      do begin
        c  = 8'($urandom_range(255));
        dc = digit_of(c);
      end while (dc[4]);
    end
    f[p] = c;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------
  // Offer one request word; returns at the edge where it is accepted, valid still
  // high, so that a following word can go out back to back.
  task automatic send_word(input logic [1:0] req, input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid    <= 1'b1;
    rx_if.req_type <= req;
    rx_if.rx_byte  <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    if (predict_word(req, b)) words_taken++;
  endtask

  // Drop valid in the step of the last acceptance.
  task automatic stop_words();
    rx_if.valid <= 1'b0;
  endtask

  // Arm, then feed the first n bytes of a frame.
  task automatic send_partial(input frame_t f, input int n);
    send_word(REQ_START, 8'($urandom_range(255)));
    for (int i = 0; i < n; i++) send_word(REQ_BYTE, f[i]);
  endtask

  // Arm and feed a whole frame, with random ticks sprinkled between bytes.
  task automatic send_frame(input frame_t f, input int tick_pct);
    send_word(REQ_START, 8'($urandom_range(255)));
    for (int i = 0; i < FRAME_BYTES; i++) begin
      while ($urandom_range(99) < tick_pct) send_word(REQ_TICK, 8'($urandom_range(255)));
      send_word(REQ_BYTE, f[i]);
    end
  endtask

  // Wait until every owed result word has come, then let in-flight words settle.
  task automatic wait_drain();
    stop_words();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register port.
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned act_v);
    fail_count++;
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  // Write the timeout limit while the block is idle and read it back. The upper
  // half of the write data is random and must be dropped.
  task automatic set_timeout(input logic [15:0] v);
    logic [31:0] rd;
    wait_drain();
    apb_write(TIMEOUT_ADDR, {16'($urandom_range(16'hFFFF)), v});
    timeout_cfg = v;
    apb_read(TIMEOUT_ADDR, rd);
    if (rd[15:0] !== v) report_mismatch("timeout_ticks readback", v, rd[15:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, with a hold-off that the pressure test raises.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none expected: expected none, actual ch %0d val %0d st %0d",
                 $time, res_if.channel, res_if.value, res_if.status);
      end else begin
        head_w = pending_words.pop_front();
        if (res_if.channel !== head_w.channel)
          report_mismatch("channel", head_w.channel, res_if.channel);
        if (res_if.value !== head_w.value)
          report_mismatch("value", head_w.value, res_if.value);
        if (res_if.status !== head_w.status)
          report_mismatch("status", head_w.status, res_if.status);
        if (res_if.last !== head_w.last)
          report_mismatch("last", head_w.last, res_if.last);
        status_seen[head_w.status]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Reset value, the largest limit and a limit of one, then back to the reset value.
  task automatic test_register_access();
    logic [31:0] rd;
    apb_read(TIMEOUT_ADDR, rd);
    if (rd[15:0] !== TIMEOUT_RESET) report_mismatch("timeout_ticks after reset",
                                                    TIMEOUT_RESET, rd[15:0]);
    set_timeout(16'hFFFF);
    set_timeout(16'd1);
    set_timeout(TIMEOUT_RESET);
  endtask

  // Bytes, ticks and the unused code while disarmed: nothing may come out.
  task automatic test_idle_words();
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_UNUSED, 8'hFF);
    wait_drain();
  endtask

  // Good frames at the level extremes, every digit, and bad hex digits at the
  // edges of the valid ranges.
  task automatic test_frame_extremes();
    frame_t f;
    send_frame(build_frame('0), 0);
    send_frame(build_frame('1), 0);
    send_frame(build_frame({12'h5A5, 12'h0F0, 12'hF0F, 12'hDEF,
                            12'hABC, 12'h789, 12'h456, 12'h123}), 0);
    f = build_frame({12'h800, 12'h001, 12'h7FE, 12'h3C3, 12'h100, 12'h999, 12'hA0A, 12'h0F1});
    f[POS_DIG_FIRST]      = "/";   // just below '0'
    f[POS_DIG_FIRST + 4]  = "a";   // lowercase
    f[POS_DIG_FIRST + 11] = "@";   // just below 'A'
    f[POS_DIG_FIRST + 15] = "G";   // just above 'F'
    f[POS_DIG_FIRST + 20] = ":";   // just above '9'
    send_frame(seal(f), 0);
    wait_drain();
  endtask

  // Checksum error, format errors at the header and trailer, and both at once.
  task automatic test_frame_errors();
    frame_t f;
    f = build_frame(random_levels());
    f[SUM_LEN] = f[SUM_LEN] + 8'd1;
    send_frame(f, 0);
    f = build_frame(random_levels());
    f[POS_STX] = CHAR_ETX;
    send_frame(seal(f), 0);
    f = build_frame(random_levels());
    f[POS_HDR1] = CHAR_ZERO;
    send_frame(seal(f), 0);
    f = build_frame(random_levels());
    f[POS_ETX] = CHAR_STX;
    send_frame(seal(f), 0);
    // Header and checksum both wrong: the checksum report wins.
    f = build_frame(random_levels());
    f[POS_HDR0] = CHAR_ONE;
    send_frame(f, 0);
    wait_drain();
  endtask

  // Restart while armed, the unused code while armed, and timeouts.
  task automatic test_restart_and_timeout();
    frame_t f;
    f = build_frame(random_levels());
    send_partial(f, 10);
    send_word(REQ_UNUSED, 8'h5A);
    send_frame(build_frame(random_levels()), 0);
    wait_drain();
    // Limit of one: the first tick times out, later words are ignored.
    set_timeout(16'd1);
    send_partial(f, 0);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_BYTE, CHAR_STX);
    wait_drain();
    // Limit of three: two ticks in a frame are fine, three mid-frame are not.
    set_timeout(16'd3);
    send_partial(f, 14);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_TICK, 8'h00);
    for (int i = 14; i < FRAME_BYTES; i++) send_word(REQ_BYTE, f[i]);
    send_partial(f, 5);
    repeat (3) send_word(REQ_TICK, 8'hFF);
    wait_drain();
  endtask

  // Largest limit: a frame with a run of ticks in it still goes through.
  task automatic test_max_timeout();
    frame_t f;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    set_timeout(16'hFFFF);
    f = build_frame(random_levels());
    send_partial(f, 0);
    repeat (20) send_word(REQ_TICK, 8'h00);
    for (int i = 0; i < FRAME_BYTES; i++) send_word(REQ_BYTE, f[i]);
    wait_drain();
    set_timeout(TIMEOUT_RESET);
  endtask

  // Hold the result side off for a long stretch while frames keep coming, so the
  // reports back up and the block stalls its request side.
  task automatic test_backpressure();
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (3) send_frame(build_frame(random_levels()), 0);
        stop_words();
      end
    join
    wait_drain();
  endtask

  // Mostly well-formed frames with random content; the rest are broken frames,
  // restarts, timeouts and stray words.
  task automatic run_random_words(input int target);
    int     first;
    int     pick;
    int     tick_pct;
    int     p;
    frame_t f;
    first = words_taken;
    while (words_taken - first < target) begin
      pick     = $urandom_range(99);
      tick_pct = $urandom_range(6);
      f        = build_frame(random_levels());
      if (pick < 55) begin
        send_frame(f, tick_pct);
      end else if (pick < 67) begin
        repeat ($urandom_range(1, 3)) f = spoil_digit(f);
        send_frame(seal(f), tick_pct);
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0:       p = POS_STX;
          1:       p = POS_HDR0;
          2:       p = POS_HDR1;
          default: p = POS_ETX;
        endcase
        f[p] = f[p] ^ 8'(1 << $urandom_range(7));
        f    = seal(f);
        if ($urandom_range(2) == 0) f[SUM_LEN] = f[SUM_LEN] ^ 8'($urandom_range(1, 255));
        send_frame(f, tick_pct);
      end else if (pick < 83) begin
        f[SUM_LEN] = f[SUM_LEN] + 8'($urandom_range(1, 255));
        send_frame(f, tick_pct);
      end else if (pick < 90) begin
        send_partial(f, $urandom_range(1, int'(SUM_LEN)));
        send_frame(build_frame(random_levels()), tick_pct);
      end else if (pick < 95 && timeout_cfg <= 16'd64) begin
        send_partial(f, $urandom_range(int'(SUM_LEN)));
        repeat (timeout_cfg) send_word(REQ_TICK, 8'($urandom_range(255)));
      end else begin
        // Stray words of any code, including a start that a later frame restarts.
        repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Four idling mixes, each with its own timeout limit.
  task automatic test_random_traffic();
    int          idle_mix[4]  = '{0, 79, 0, 23};
    int          stall_mix[4] = '{0, 0, 79, 23};
    logic [15:0] limits[4]    = '{16'd100, 16'hFFFF, 16'd7, 16'd1};
    for (int ph = 0; ph < 4; ph++) begin
      set_timeout(limits[ph]);
      send_idle_pct = idle_mix[ph];
      rx_stall_pct  = stall_mix[ph];
      run_random_words(30);
      wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input before the first edge.
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.req_type = REQ_BYTE;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rx_hold        = 1'b0;
    send_idle_pct  = 0;
    rx_stall_pct   = 0;
    fail_count     = 0;
    words_taken    = 0;
    words_seen     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    timeout_cfg    = TIMEOUT_RESET;
    arm_q          = 1'b0;
    clear_frame_state();

    // Hold reset, then release it on an edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_idle_words();
    test_frame_extremes();
    test_frame_errors();
    test_restart_and_timeout();
    test_max_timeout();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    $display("summary: %0d request words taken, %0d result words checked, %0d ok channels",
             words_taken, words_seen, status_seen[ST_OK]);
    $display("summary: %0d timeouts, %0d checksum, %0d format, %0d bad-hex reports",
             status_seen[ST_TIMEOUT], status_seen[ST_CKSUM], status_seen[ST_FORMAT],
             status_seen[ST_BADHEX]);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/afr_pkg.sv
hw/rtl/afr_if.sv
hw/rtl/afr_regs.sv
hw/rtl/afr_parser.sv
hw/rtl/afr_emitter.sv
hw/rtl/analog_frame_receiver.sv
verif/tb_top.sv
